// File: src/mtea_pkg.sv
// ----------------------------------------------------------------------------
// mtea_pkg
// shared types, constants and q16.16 helpers for the mass-term assembly block
// ----------------------------------------------------------------------------
package mtea_pkg;

  localparam int NODES_DEF  = 8;
  localparam int DIMS_DEF   = 3;
  localparam int POINTS_DEF = 8;
  localparam int LEVELS     = 3;

  // input modes
  localparam logic [1:0] MODE_NODE  = 2'd0;
  localparam logic [1:0] MODE_SHAPE = 2'd1;
  localparam logic [1:0] MODE_POINT = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_GNEW  = 3'd0;
  localparam logic [2:0] REG_GCUR  = 3'd1;
  localparam logic [2:0] REG_GOLD  = 3'd2;
  localparam logic [2:0] REG_INV   = 3'd3;
  localparam logic [2:0] REG_RELAX = 3'd4;

  // result kinds
  localparam logic KIND_RES = 1'b0;
  localparam logic KIND_MAT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INTERP,   // shape-weighted sums, one product per issue and collect phase pair
    ST_MOM,      // rho*u for each level and component
    ST_GSUM,     // gamma weighted sum
    ST_TV,       // times subvolume
    ST_TI,       // times inverse step
    ST_GV,       // gradient times subvolume
    ST_RES_OUT,  // final result word draining
    ST_FAC,      // diagonal factor chain
    ST_MAT,      // matrix product
    ST_MAT_OUT   // matrix word waiting
  } state_t;

  // product request to the shared multiplier
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'sh0_7fff_ffff_ffff) return 48'sh7fff_ffff_ffff;
    if (v < -50'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

endpackage

// File: src/mtea_mul.sv
// ----------------------------------------------------------------------------
// mtea_mul
// shared q16.16 multiplier: 32x32 product, round half up, registered result
// ----------------------------------------------------------------------------
module mtea_mul (
  input  logic                clk,
  input  mtea_pkg::mul_req_t  req,
  output logic signed [47:0]  prod_r
);
  import mtea_pkg::*;

  logic signed [63:0] full;
  logic signed [47:0] prod_nxt;

  // product rounded to q32.16, floor after adding one half
  always_comb begin
    full     = 64'(req.a) * 64'(req.b);
    full     = full + 64'sd32768;
    prod_nxt = full[63:16];
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// File: src/mass_term_element_assembly_top.sv
// ----------------------------------------------------------------------------
// mass_term_element_assembly_top
// time-term assembly for one element with a shared multiplier sequencer
// ----------------------------------------------------------------------------
// Usage: load node words (mode 0) and shape weights (mode 1), then send one
// compute word (mode 2) per integration point. The user writes configuration
// on the cfg_ port only while the block is idle; the block does not enforce it.
// Load words are accepted while the block is idle. A compute word runs the
// shared multiplier once per product, in an issue and an accumulate phase,
// and delivers DIMS+NODES result words along the way.
// in_ready is low from the compute word until its last result is taken.
// A result waits in the output register while out_ready is low; the
// sequencer halts when its next word is ready until the waiting one is
// taken. Reset clears control and sets the configuration registers to
// their default values; node and shape stores and datapath registers hold
// no reset value.
// ----------------------------------------------------------------------------
module mass_term_element_assembly_top #(
  parameter int NODES  = mtea_pkg::NODES_DEF,
  parameter int DIMS   = mtea_pkg::DIMS_DEF,
  parameter int POINTS = mtea_pkg::POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [2:0]         in_node,
  input  logic [1:0]         in_comp,
  input  logic [2:0]         in_point,
  input  logic signed [31:0] in_rho_old,
  input  logic signed [31:0] in_rho_cur,
  input  logic signed [31:0] in_rho_new,
  input  logic signed [31:0] in_vel_old,
  input  logic signed [31:0] in_vel_cur,
  input  logic signed [31:0] in_vel_new,
  input  logic signed [31:0] in_press_grad,
  input  logic signed [31:0] in_weight,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [2:0]         out_row_node,
  output logic [2:0]         out_col_node,
  output logic [1:0]         out_comp_out,
  output logic signed [47:0] out_amount,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import mtea_pkg::*;

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int DW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int PW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int DD = LEVELS * NODES;
  localparam int VD = LEVELS * NODES * DIMS;
  localparam int GD = NODES * DIMS;
  localparam int SD = POINTS * NODES;
  localparam int DAW = $clog2(DD);
  localparam int VAW = $clog2(VD);
  localparam int GAW = $clog2(GD);
  localparam int SAW = $clog2(SD);
  // interpolated values: LEVELS rho, LEVELS*DIMS u, DIMS grad
  localparam int NI  = LEVELS + LEVELS * DIMS + DIMS;
  localparam int IW  = $clog2(NI);

  // stores
  logic signed [31:0] dens_mem [DD];
  logic signed [31:0] velo_mem [VD];
  logic signed [31:0] grad_mem [GD];
  logic signed [31:0] shp_mem  [SD];

  // configuration registers
  logic signed [31:0] g_new_r, g_cur_r, g_old_r;
  logic [30:0]        inv_r, relax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_new_r <= 32'sd65536;
      g_cur_r <= -32'sd65536;
      g_old_r <= 32'sd0;
      inv_r   <= 31'd65536;
      relax_r <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GNEW:  g_new_r <= cfg_data;
        REG_GCUR:  g_cur_r <= cfg_data;
        REG_GOLD:  g_old_r <= cfg_data;
        REG_INV:   inv_r   <= cfg_data[30:0];
        REG_RELAX: relax_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // sequencer registers
  state_t             state_r, state_nxt;
  logic [IW-1:0]      iv_r, iv_nxt;        // interpolated value index
  logic [NW-1:0]      ic_r, ic_nxt;        // node counter
  logic [DW-1:0]      j_r, j_nxt;          // component
  logic [1:0]         lv_r, lv_nxt;        // level / step counter
  logic               ph_r, ph_nxt;        // 0 issue, 1 collect
  logic [2:0]         node_r;
  logic [PW-1:0]      pt_r;
  logic signed [31:0] w_r;
  logic signed [49:0] acc_r, acc_nxt;
  logic signed [31:0] ival_r [NI];
  logic signed [31:0] mom_r  [LEVELS];
  logic signed [31:0] t_r, t_nxt;          // gamma sum, then t*vol
  logic signed [47:0] ti_r, ti_nxt;
  logic signed [31:0] fac_r, fac_nxt;
  logic               ival_we;
  logic               mom_we;

  // output register
  logic               ov_r, ov_nxt;
  logic               ok_r;
  logic [2:0]         oc_r;
  logic [1:0]         ocmp_r;
  logic signed [47:0] oa_r;
  logic               ol_r;
  logic               o_load;
  logic               o_kind;
  logic [1:0]         o_cmp;
  logic [2:0]         o_col;
  logic signed [47:0] o_amt;
  logic               o_last;

  // shared multiplier
  mul_req_t           mreq;
  logic signed [47:0] prod;

  mtea_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (prod)
  );

  logic in_acc, node_ok, pt_ok, comp_ok;
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign node_ok  = 32'(in_node) < NODES;
  assign pt_ok    = 32'(in_point) < POINTS;
  assign comp_ok  = 32'(in_comp) < DIMS;

  // store writes
  always_ff @(posedge clk) begin
    if (in_acc && node_ok && in_mode == MODE_NODE && comp_ok) begin
      dens_mem[DAW'(0 * NODES + 32'(in_node))] <= in_rho_old;
      dens_mem[DAW'(1 * NODES + 32'(in_node))] <= in_rho_cur;
      dens_mem[DAW'(2 * NODES + 32'(in_node))] <= in_rho_new;
      velo_mem[VAW'((0 * NODES + 32'(in_node)) * DIMS + 32'(in_comp))] <= in_vel_old;
      velo_mem[VAW'((1 * NODES + 32'(in_node)) * DIMS + 32'(in_comp))] <= in_vel_cur;
      velo_mem[VAW'((2 * NODES + 32'(in_node)) * DIMS + 32'(in_comp))] <= in_vel_new;
      grad_mem[GAW'(32'(in_node) * DIMS + 32'(in_comp))] <= in_press_grad;
    end
    if (in_acc && node_ok && pt_ok && in_mode == MODE_SHAPE) begin
      shp_mem[SAW'(32'(in_point) * NODES + 32'(in_node))] <= in_weight;
    end
  end

  // registered store reads for the interpolation operands
  logic signed [31:0] shp_q, fld_q;
  logic [1:0]         iv_lvl;
  logic [DW-1:0]      iv_dim;
  int                 iv_off;

  // level and component of an interpolated value by compare and subtract
  always_comb begin
    iv_lvl = 2'd0;
    iv_dim = '0;
    iv_off = 32'(iv_r) - LEVELS;
    if (32'(iv_r) < LEVELS) begin
      iv_lvl = 2'(iv_r);
    end else if (32'(iv_r) < LEVELS + LEVELS * DIMS) begin
      if (iv_off >= 2 * DIMS) begin
        iv_lvl = 2'd2;
        iv_dim = DW'(iv_off - 2 * DIMS);
      end else if (iv_off >= DIMS) begin
        iv_lvl = 2'd1;
        iv_dim = DW'(iv_off - DIMS);
      end else begin
        iv_dim = DW'(iv_off);
      end
    end else begin
      iv_dim = DW'(32'(iv_r) - LEVELS - LEVELS * DIMS);
    end
  end

  always_ff @(posedge clk) begin
    shp_q <= shp_mem[SAW'(32'(pt_r) * NODES + 32'(ic_r))];
    if (32'(iv_r) < LEVELS)
      fld_q <= dens_mem[DAW'(32'(iv_lvl) * NODES + 32'(ic_r))];
    else if (32'(iv_r) < LEVELS + LEVELS * DIMS)
      fld_q <= velo_mem[VAW'((32'(iv_lvl) * NODES + 32'(ic_r)) * DIMS + 32'(iv_dim))];
    else
      fld_q <= grad_mem[GAW'(32'(ic_r) * DIMS + 32'(iv_dim))];
  end

  // gamma for the current level of the weighted sum
  logic signed [31:0] gam;
  always_comb begin
    case (lv_r)
      2'd0:    gam = g_new_r;
      2'd1:    gam = g_cur_r;
      default: gam = g_old_r;
    endcase
  end

  logic signed [31:0] u_sel;
  always_comb begin
    u_sel = ival_r[IW'(LEVELS + 32'(lv_r) * DIMS + 32'(j_r))];
  end

  // multiplier operand selection
  always_comb begin
    mreq.a = shp_q;
    mreq.b = fld_q;
    case (state_r)
      ST_MOM: begin
        mreq.a = ival_r[IW'(lv_r)];
        mreq.b = u_sel;
      end
      ST_GSUM: begin
        mreq.a = gam;
        mreq.b = mom_r[2'd2 - lv_r];
      end
      ST_TV: begin
        mreq.a = t_r;
        mreq.b = w_r;
      end
      ST_TI: begin
        mreq.a = t_r;
        mreq.b = {1'b0, inv_r};
      end
      ST_GV: begin
        mreq.a = ival_r[IW'(LEVELS + LEVELS * DIMS + 32'(j_r))];
        mreq.b = w_r;
      end
      ST_FAC: begin
        case (lv_r)
          2'd0:    begin mreq.a = g_new_r; mreq.b = ival_r[IW'(2)]; end
          2'd1:    begin mreq.a = fac_r;   mreq.b = w_r; end
          2'd2:    begin mreq.a = fac_r;   mreq.b = {1'b0, inv_r}; end
          default: begin mreq.a = fac_r;   mreq.b = {1'b0, relax_r}; end
        endcase
      end
      ST_MAT, ST_MAT_OUT: begin
        // operands held while the matrix word waits, so the product stays
        mreq.a = shp_q;
        mreq.b = fac_r;
      end
      default: ;
    endcase
  end

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    iv_nxt    = iv_r;
    ic_nxt    = ic_r;
    j_nxt     = j_r;
    lv_nxt    = lv_r;
    ph_nxt    = ph_r;
    acc_nxt   = acc_r;
    t_nxt     = t_r;
    ti_nxt    = ti_r;
    fac_nxt   = fac_r;
    ival_we   = 1'b0;
    mom_we    = 1'b0;
    o_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_mode == MODE_POINT && node_ok && pt_ok) begin
          state_nxt = ST_INTERP;
          iv_nxt = '0; ic_nxt = '0; ph_nxt = 1'b0; acc_nxt = '0; lv_nxt = '0;
        end
      end
      ST_INTERP: begin
        // phase 0 reads stores, phase 1 multiplies, the next phase 1 adds
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (lv_r == 2'd1) acc_nxt = acc_r + 50'(prod);
          lv_nxt = 2'd1;
          if (32'(ic_r) == NODES - 1) begin
            state_nxt = ST_INTERP;
            lv_nxt = 2'd2;
          end else begin
            ic_nxt = ic_r + 1'b1;
          end
        end
        if (lv_r == 2'd2 && ph_r) begin
          // final product of this value lands now
          ival_we = 1'b1;
          acc_nxt = '0;
          lv_nxt  = 2'd0;
          ic_nxt  = '0;
          if (32'(iv_r) == NI - 1) begin
            state_nxt = ST_MOM;
            lv_nxt = 2'd0; j_nxt = '0;
          end else begin
            iv_nxt = iv_r + 1'b1;
          end
        end
      end
      ST_MOM: begin
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          ph_nxt = 1'b0; mom_we = 1'b1;
          if (lv_r == 2'd2) begin lv_nxt = 2'd0; acc_nxt = '0; state_nxt = ST_GSUM; end
          else lv_nxt = lv_r + 1'b1;
        end
      end
      ST_GSUM: begin
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          ph_nxt = 1'b0;
          acc_nxt = acc_r + 50'(prod);
          if (lv_r == 2'd2) begin
            lv_nxt = 2'd0;
            t_nxt = sat32(acc_r + 50'(prod));
            state_nxt = ST_TV;
          end else lv_nxt = lv_r + 1'b1;
        end
      end
      ST_TV: begin
        if (!ph_r) ph_nxt = 1'b1;
        else begin ph_nxt = 1'b0; t_nxt = sat32(50'(prod)); state_nxt = ST_TI; end
      end
      ST_TI: begin
        if (!ph_r) ph_nxt = 1'b1;
        else begin ph_nxt = 1'b0; ti_nxt = prod; state_nxt = ST_GV; end
      end
      ST_GV: begin
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          ph_nxt = 1'b0;
          if (!ov_r || out_ready) begin
            o_load = 1'b1;
            if (32'(j_r) == DIMS - 1) begin
              state_nxt = ST_FAC; lv_nxt = 2'd0;
            end else begin
              j_nxt = j_r + 1'b1; state_nxt = ST_MOM; lv_nxt = 2'd0;
            end
          end else begin
            ph_nxt = 1'b1; // hold, product stays since operands unchanged
          end
        end
      end
      ST_FAC: begin
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          ph_nxt = 1'b0;
          fac_nxt = sat32(50'(prod));
          if (lv_r == 2'd3) begin state_nxt = ST_MAT; ic_nxt = '0; end
          else lv_nxt = lv_r + 1'b1;
        end
      end
      ST_MAT: begin
        // phase 0 shape read, phase 1 multiply, collect when output free
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          state_nxt = ST_MAT_OUT;
        end
      end
      ST_MAT_OUT: begin
        if (!ov_r || out_ready) begin
          o_load = 1'b1;
          ph_nxt = 1'b0;
          if (32'(ic_r) == NODES - 1) state_nxt = ST_RES_OUT;
          else begin ic_nxt = ic_r + 1'b1; state_nxt = ST_MAT; end
        end
      end
      ST_RES_OUT: begin
        // wait for the final word to drain
        if (!ov_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output word contents
  always_comb begin
    o_kind = KIND_RES;
    o_cmp  = 2'(j_r);
    o_col  = 3'd0;
    o_amt  = sat48(-50'(ti_r) - 50'(prod));
    o_last = 1'b0;
    if (state_r == ST_MAT_OUT) begin
      o_kind = KIND_MAT;
      o_cmp  = 2'd0;
      o_col  = 3'(ic_r);
      o_amt  = prod;
      o_last = (32'(ic_r) == NODES - 1);
    end
  end

  assign ov_nxt = o_load ? 1'b1 : (out_ready ? 1'b0 : ov_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      ph_r    <= 1'b0;
      lv_r    <= 2'd0;
      ic_r    <= '0;
      iv_r    <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      ph_r    <= ph_nxt;
      lv_r    <= lv_nxt;
      ic_r    <= ic_nxt;
      iv_r    <= iv_nxt;
      j_r     <= j_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    t_r   <= t_nxt;
    ti_r  <= ti_nxt;
    fac_r <= fac_nxt;
    if (in_acc) begin
      node_r <= in_node;
      pt_r   <= PW'(in_point);
      w_r    <= in_weight;
    end
    if (ival_we) ival_r[iv_r] <= sat32(acc_r + 50'(prod));
    if (mom_we) mom_r[lv_r] <= sat32(50'(prod));
    if (o_load) begin
      ok_r   <= o_kind;
      oc_r   <= o_col;
      ocmp_r <= o_cmp;
      oa_r   <= o_amt;
      ol_r   <= o_last;
    end
  end

  assign out_valid    = ov_r;
  assign out_kind     = ok_r;
  assign out_row_node = node_r;
  assign out_col_node = oc_r;
  assign out_comp_out = ocmp_r;
  assign out_amount   = oa_r;
  assign out_last     = ol_r;

endmodule

// File: bench/mtea_checker.sv
// ----------------------------------------------------------------------------
// mtea_checker
// watches the load, compute and result channels of the mass-term assembly
// block, keeps its own copy of the element stores and registers, predicts
// every residual and diagonal word and compares them in order
// ----------------------------------------------------------------------------
module mtea_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [2:0]         in_node,
  input  logic [1:0]         in_comp,
  input  logic [2:0]         in_point,
  input  logic signed [31:0] in_rho_old,
  input  logic signed [31:0] in_rho_cur,
  input  logic signed [31:0] in_rho_new,
  input  logic signed [31:0] in_vel_old,
  input  logic signed [31:0] in_vel_cur,
  input  logic signed [31:0] in_vel_new,
  input  logic signed [31:0] in_press_grad,
  input  logic signed [31:0] in_weight,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_kind,
  input  logic [2:0]         out_row_node,
  input  logic [2:0]         out_col_node,
  input  logic [1:0]         out_comp_out,
  input  logic signed [47:0] out_amount,
  input  logic               out_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 words_pending,
  output int                 words_checked,
  output int                 points_seen
);
  import mtea_pkg::*;

  localparam int NODES  = NODES_DEF;
  localparam int DIMS   = DIMS_DEF;
  localparam int POINTS = POINTS_DEF;

  typedef struct {
    logic               kind;
    logic [2:0]         row_node;
    logic [2:0]         col_node;
    logic [1:0]         comp_out;
    logic signed [47:0] amount;
    logic               last;
  } incr_t;

  // element stores, level 0 old, 1 cur, 2 new
  longint dens_q [LEVELS][NODES];
  longint velo_q [LEVELS][NODES][DIMS];
  longint grad_q [NODES][DIMS];
  longint shape_q[POINTS][NODES];
  longint g_new, g_cur, g_old, inv_step, relax;

  incr_t expected_incr[$];

  initial begin
    fail_count    = 0;
    words_pending = 0;
    words_checked = 0;
    points_seen   = 0;
  end

  function automatic longint qmul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [47:0] clamp48(longint v);
    longint lim;
    lim = 64'sh7fff_ffff_ffff;
    if (v > lim) return 48'sh7fff_ffff_ffff;
    if (v < -lim - 1) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  function automatic incr_t make_incr(logic kind, int row, int col, int comp,
                                      longint amt, logic last);
    incr_t e;
    e.kind     = kind;
    e.row_node = row[2:0];
    e.col_node = col[2:0];
    e.comp_out = comp[1:0];
    e.amount   = clamp48(amt);
    e.last     = last;
    return e;
  endfunction

  // interpolate fields at one point and queue its increments
  task automatic assemble_point(int pt, int near, longint vol);
    longint rho[LEVELS];
    longint u[LEVELS][DIMS];
    longint gj[DIMS];
    longint acc, m0, m1, m2, t, tv, ti, gv, fac;
    for (int k = 0; k < LEVELS; k++) begin
      acc = 0;
      for (int ic = 0; ic < NODES; ic++) acc += qmul(shape_q[pt][ic], dens_q[k][ic]);
      rho[k] = clamp32(acc);
      for (int j = 0; j < DIMS; j++) begin
        acc = 0;
        for (int ic = 0; ic < NODES; ic++)
          acc += qmul(shape_q[pt][ic], velo_q[k][ic][j]);
        u[k][j] = clamp32(acc);
      end
    end
    for (int j = 0; j < DIMS; j++) begin
      acc = 0;
      for (int ic = 0; ic < NODES; ic++) acc += qmul(shape_q[pt][ic], grad_q[ic][j]);
      gj[j] = clamp32(acc);
    end
    // residual per component
    for (int j = 0; j < DIMS; j++) begin
      m0 = clamp32(qmul(rho[0], u[0][j]));
      m1 = clamp32(qmul(rho[1], u[1][j]));
      m2 = clamp32(qmul(rho[2], u[2][j]));
      t  = clamp32(qmul(g_new, m2) + qmul(g_cur, m1) + qmul(g_old, m0));
      tv = clamp32(qmul(t, vol));
      ti = qmul(tv, inv_step);
      gv = qmul(gj[j], vol);
      expected_incr.push_back(make_incr(KIND_RES, near, 0, j, -ti - gv, 1'b0));
    end
    // diagonal factor chain, then one matrix word per node
    fac = clamp32(qmul(g_new, rho[2]));
    fac = clamp32(qmul(fac, vol));
    fac = clamp32(qmul(fac, inv_step));
    fac = clamp32(qmul(fac, relax));
    for (int ic = 0; ic < NODES; ic++)
      expected_incr.push_back(make_incr(KIND_MAT, near, ic, 0,
                                        qmul(shape_q[pt][ic], fac), ic == NODES - 1));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      g_new    = 65536;
      g_cur    = -65536;
      g_old    = 0;
      inv_step = 65536;
      relax    = 65536;
      expected_incr.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_GNEW:  g_new    = longint'(signed'(cfg_data));
          REG_GCUR:  g_cur    = longint'(signed'(cfg_data));
          REG_GOLD:  g_old    = longint'(signed'(cfg_data));
          REG_INV:   inv_step = longint'({1'b0, cfg_data[30:0]});
          REG_RELAX: relax    = longint'({1'b0, cfg_data[30:0]});
          default: ;
        endcase
      end

      // result words against the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_incr.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          incr_t e;
          e = expected_incr.pop_front();
          words_checked++;
          if (out_kind !== e.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", e.kind, out_kind);
            fail_count++;
          end
          if (out_row_node !== e.row_node) begin
            $error("row_node mismatch: expected %0d, actual %0d", e.row_node, out_row_node);
            fail_count++;
          end
          if (out_col_node !== e.col_node) begin
            $error("col_node mismatch: expected %0d, actual %0d", e.col_node, out_col_node);
            fail_count++;
          end
          if (out_comp_out !== e.comp_out) begin
            $error("comp_out mismatch: expected %0d, actual %0d", e.comp_out, out_comp_out);
            fail_count++;
          end
          if (out_amount !== e.amount) begin
            $error("amount mismatch: expected %0d, actual %0d", e.amount, out_amount);
            fail_count++;
          end
          if (out_last !== e.last) begin
            $error("last mismatch: expected %0d, actual %0d", e.last, out_last);
            fail_count++;
          end
        end
      end

      // accepted input words
      if (in_valid && in_ready) begin
        case (in_mode)
          MODE_NODE: begin
            if (in_comp < DIMS) begin
              dens_q[0][in_node] = in_rho_old;
              dens_q[1][in_node] = in_rho_cur;
              dens_q[2][in_node] = in_rho_new;
              velo_q[0][in_node][in_comp] = in_vel_old;
              velo_q[1][in_node][in_comp] = in_vel_cur;
              velo_q[2][in_node][in_comp] = in_vel_new;
              grad_q[in_node][in_comp] = in_press_grad;
            end
          end
          MODE_SHAPE: shape_q[in_point][in_node] = in_weight;
          MODE_POINT: begin
            points_seen++;
            assemble_point(in_point, in_node, longint'(in_weight));
          end
          default: ;
        endcase
      end
      words_pending = expected_incr.size();
    end
  end

endmodule

// File: bench/tb_mass_term_element_assembly_top.sv
// ----------------------------------------------------------------------------
// tb_mass_term_element_assembly_top
// loads element data and shape tables, sends integration points under
// several register settings with bursty input and a stalling receiver;
// the checker beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_mass_term_element_assembly_top;
  import mtea_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_mode;
  logic [2:0]         in_node;
  logic [1:0]         in_comp;
  logic [2:0]         in_point;
  logic signed [31:0] in_rho_old, in_rho_cur, in_rho_new;
  logic signed [31:0] in_vel_old, in_vel_cur, in_vel_new;
  logic signed [31:0] in_press_grad;
  logic signed [31:0] in_weight;
  logic               out_valid;
  logic               out_ready;
  logic               out_kind;
  logic [2:0]         out_row_node;
  logic [2:0]         out_col_node;
  logic [1:0]         out_comp_out;
  logic signed [47:0] out_amount;
  logic               out_last;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  int fail_count, words_pending, words_checked, points_seen;

  typedef struct {
    logic [1:0]  mode;
    logic [2:0]  node;
    logic [1:0]  comp;
    logic [2:0]  point;
    logic [31:0] rho[3];
    logic [31:0] vel[3];
    logic [31:0] grad;
    logic [31:0] weight;
  } load_word_t;

  logic [7:0] shape_written[8];
  int         burst_left;
  int         words_sent;

  mass_term_element_assembly_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_node(in_node), .in_comp(in_comp), .in_point(in_point),
    .in_rho_old(in_rho_old), .in_rho_cur(in_rho_cur), .in_rho_new(in_rho_new),
    .in_vel_old(in_vel_old), .in_vel_cur(in_vel_cur), .in_vel_new(in_vel_new),
    .in_press_grad(in_press_grad), .in_weight(in_weight),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_row_node(out_row_node), .out_col_node(out_col_node),
    .out_comp_out(out_comp_out), .out_amount(out_amount), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mtea_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_node(in_node), .in_comp(in_comp), .in_point(in_point),
    .in_rho_old(in_rho_old), .in_rho_cur(in_rho_cur), .in_rho_new(in_rho_new),
    .in_vel_old(in_vel_old), .in_vel_cur(in_vel_cur), .in_vel_new(in_vel_new),
    .in_press_grad(in_press_grad), .in_weight(in_weight),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_row_node(out_row_node), .out_col_node(out_col_node),
    .out_comp_out(out_comp_out), .out_amount(out_amount), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .words_pending(words_pending),
    .words_checked(words_checked), .points_seen(points_seen)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  initial begin
    #(8 * 2000000);
    $display("Verification failed");
    $finish;
  end

  // receiver: stall pattern picked at random in turn, one long hold-off
  initial begin
    int pattern, hold, held;
    out_ready = 1'b0;
    held = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      pattern = $urandom_range(0, 3);
      for (int c = 0; c < 64; c++) begin
        if (!held && points_seen >= 12) begin
          held = 1;
          out_ready <= 1'b0;
          hold = 0;
          while (hold < 3000) begin
            @(posedge clk);
            hold++;
          end
        end
        case (pattern)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // q16.16 value, extremes often
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      4, 5: return $urandom;
      default: return $urandom_range(0, 262143) - 131072;
    endcase
  endfunction

  // shape weight or volume, mostly within a unit
  function automatic logic [31:0] pick_weight();
    if ($urandom_range(0, 7) == 0) return pick_value();
    return $urandom_range(0, 65536) - ($urandom_range(0, 3) == 0 ? 32768 : 0);
  endfunction

  function automatic load_word_t node_word(int node, int comp);
    load_word_t w;
    w.mode  = MODE_NODE;
    w.node  = 3'(node);
    w.comp  = 2'(comp);
    w.point = 3'($urandom_range(0, 7));
    for (int k = 0; k < 3; k++) begin
      w.rho[k] = pick_value();
      w.vel[k] = pick_value();
    end
    w.grad   = pick_value();
    w.weight = $urandom;
    return w;
  endfunction

  function automatic load_word_t shape_word(int point, int node, logic [31:0] wt);
    load_word_t w;
    w = node_word(node, 0);
    w.mode   = MODE_SHAPE;
    w.point  = 3'(point);
    w.comp   = 2'($urandom_range(0, 3));
    w.weight = wt;
    return w;
  endfunction

  function automatic load_word_t point_word(int point, int near, logic [31:0] vol);
    load_word_t w;
    w = shape_word(point, near, vol);
    w.mode = MODE_POINT;
    return w;
  endfunction

  // offer one word, hold until accepted, then burst on or leave a gap
  task automatic send_word(input load_word_t w);
    if (w.mode == MODE_SHAPE) shape_written[w.point][w.node] = 1'b1;
    in_valid      <= 1'b1;
    in_mode       <= w.mode;
    in_node       <= w.node;
    in_comp       <= w.comp;
    in_point      <= w.point;
    in_rho_old    <= w.rho[0];
    in_rho_cur    <= w.rho[1];
    in_rho_new    <= w.rho[2];
    in_vel_old    <= w.vel[0];
    in_vel_cur    <= w.vel[1];
    in_vel_new    <= w.vel[2];
    in_press_grad <= w.grad;
    in_weight     <= w.weight;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // random word: mostly loads and points, some ignored noise
  task automatic random_word();
    int r, pt;
    load_word_t w;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      do pt = $urandom_range(0, 7); while (shape_written[pt] != 8'hff);
      w = point_word(pt, $urandom_range(0, 7), pick_weight());
    end else if (r < 75) begin
      w = node_word($urandom_range(0, 7), $urandom_range(0, 2));
    end else if (r < 93) begin
      w = shape_word($urandom_range(0, 7), $urandom_range(0, 7), pick_weight());
    end else if (r < 97) begin
      w = node_word($urandom_range(0, 7), 3);
    end else begin
      w = node_word($urandom_range(0, 7), $urandom_range(0, 3));
      w.mode = MODE_NONE;
    end
    send_word(w);
  endtask

  // drain all results, let the block go idle
  task automatic settle();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    burst_left = 0;
    while (words_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] gn, input logic [31:0] gc,
                            input logic [31:0] go, input logic [31:0] inv,
                            input logic [31:0] rl);
    logic [31:0] vals[5];
    vals = '{gn, gc, go, inv, rl};
    cfg_we <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stimulus
  initial begin
    load_word_t w;
    in_valid = 1'b0; in_mode = MODE_NODE; in_node = '0; in_comp = '0; in_point = '0;
    in_rho_old = '0; in_rho_cur = '0; in_rho_new = '0;
    in_vel_old = '0; in_vel_cur = '0; in_vel_new = '0;
    in_press_grad = '0; in_weight = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    burst_left = 0;
    words_sent = 0;
    for (int p = 0; p < 8; p++) shape_written[p] = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every node and component, then the table of point 0
    for (int n = 0; n < 8; n++)
      for (int c = 0; c < 3; c++) send_word(node_word(n, c));
    for (int n = 0; n < 8; n++) send_word(shape_word(0, n, pick_weight()));

    // directed: extreme table for point 1, extreme volumes, ignored words
    send_word(point_word(0, 0, 32'h0001_0000));
    for (int n = 0; n < 8; n++)
      send_word(shape_word(1, n, (n == 0) ? 32'h7fff_ffff : (n == 1) ? 32'h8000_0000 :
                                 (n == 2) ? 32'h0 : 32'h0001_0000));
    send_word(point_word(1, 7, 32'h7fff_ffff));
    send_word(point_word(1, 0, 32'h8000_0000));
    w = node_word(0, 0);
    w.rho = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    w.vel = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff};
    w.grad = 32'h8000_0000;
    send_word(w);
    w = node_word(1, 3);
    send_word(w);
    w = node_word(2, 1);
    w.mode = MODE_NONE;
    send_word(w);
    send_word(point_word(1, 3, 32'hffff_ffff));
    send_word(point_word(0, 5, 32'h0));

    // phases of register settings
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: write_regs(32'h0001_8000, 32'hfffe_0000, 32'h0000_8000, 32'h000a_0000,
                      32'h0001_0000);
        1: write_regs(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'hffff_ffff);
        2: write_regs(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);
        3: write_regs(pick_value(), pick_value(), pick_value(), $urandom, $urandom);
        default: write_regs(32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0001_0000,
                            32'h0001_0000);
      endcase
      for (int i = 0; i < 42; i++) random_word();
    end

    settle();
    repeat (600) @(posedge clk);
    $display("covered %0d input words, %0d integration points, %0d result words",
             words_sent, points_seen, words_checked);
    $display("five register settings including both extremes, bursty input, long stall");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
